### hdl/vrt_pkg.sv
// ----------------------------------------------------------------------------
// vrt_pkg
// Shared widths, codes and types of the voxel ray traversal block.
// ----------------------------------------------------------------------------
package vrt_pkg;

   localparam int ORG_W       = 24;
   localparam int DIR_W       = 18;
   localparam int CFG_W       = 5;
   localparam int VOX_W       = 4;
   localparam int IDX_W       = 6;
   localparam int FRAC_W      = 16;
   localparam int POS_W       = 22;
   localparam int MAG_W       = 18;
   localparam int NUM_W       = 42;
   localparam int MCAND_W     = 44;
   localparam int ACC_W       = 61;
   localparam int T_W         = 44;
   localparam int INC_W       = 33;
   localparam int BT_W        = 48;
   localparam int CNT_W       = 6;
   localparam int DIV_STEPS   = 42;
   localparam int MUL_STEPS   = 18;
   localparam int MAX_RESULTS = 46;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z = 2'd2;

   localparam logic [1:0] AX_LAST = 2'd2;

   typedef enum logic {
      OP_DIV,
      OP_MUL
   } alu_op_type;

   typedef enum logic [3:0] {
      SU_IDLE,
      SU_CHECK,
      SU_SLAB_GO1,
      SU_SLAB_WT1,
      SU_SLAB_GO2,
      SU_SLAB_WT2,
      SU_SLAB_UPD,
      SU_DECIDE,
      SU_ENTRY_GO,
      SU_ENTRY_WT,
      SU_CELL,
      SU_REC_GO,
      SU_REC_WT,
      SU_BT_GO,
      SU_BT_WT,
      SU_DONE
   } setup_state_type;

   typedef struct packed {
      logic                    miss;
      logic                    all_zero;
      logic [2:0]              sgn;
      logic [2:0][IDX_W-1:0]   idx;
      logic [2:0][BT_W-1:0]    bt;
      logic [2:0][INC_W-1:0]   inc;
   } ray_setup_type;

endpackage

### hdl/vrt_alu.sv
// ----------------------------------------------------------------------------
// vrt_alu
// Shared iterative unit: restoring divide and shift-add multiply, one bit
// per cycle.
// ----------------------------------------------------------------------------
module vrt_alu import vrt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  alu_op_type         op,
   input  logic [MCAND_W-1:0] opa,
   input  logic [MAG_W-1:0]   opb,
   output logic               done,
   output logic [ACC_W-1:0]   result
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   alu_op_type         op_ff, op_in;
   logic [MCAND_W-1:0] a_ff, a_in;
   logic [MAG_W-1:0]   b_ff, b_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [MAG_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [MAG_W:0]     rem_sh;
   logic [MAG_W+1:0]   diff;
   logic               qbit;
   logic [ACC_W-1:0]   addend;

   always_comb begin
      rem_sh = {rem_ff, a_ff[NUM_W-1]};
      diff   = {1'b0, rem_sh} - {2'b0, b_ff};
      qbit   = !diff[MAG_W+1];
      addend = b_ff[MAG_W-1] ? {{(ACC_W-MCAND_W){1'b0}}, a_ff} : '0;

      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;

      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         a_in    = opa;
         b_in    = opb;
         acc_in  = '0;
         rem_in  = '0;
         cnt_in  = (op == OP_DIV) ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            rem_in = qbit ? diff[MAG_W-1:0] : rem_sh[MAG_W-1:0];
            a_in   = {a_ff[MCAND_W-2:0], 1'b0};
            acc_in = {acc_ff[ACC_W-2:0], qbit};
         end else begin
            acc_in = {acc_ff[ACC_W-2:0], 1'b0} + addend;
            b_in   = {b_ff[MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("alu started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff)) else $error("alu done without work");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff && op_ff == OP_DIV |-> rem_ff < b_ff) else $error("alu remainder overflow");
`endif

endmodule

### hdl/vrt_setup.sv
// ----------------------------------------------------------------------------
// vrt_setup
// Ray setup sequencer: inside test, slab test, entry point, first cell,
// time increments and first boundary times through the shared unit.
// ----------------------------------------------------------------------------
module vrt_setup import vrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2:0][CFG_W-1:0] cells_n,
   input  logic [ORG_W-1:0]      origin_x,
   input  logic [ORG_W-1:0]      origin_y,
   input  logic [ORG_W-1:0]      origin_z,
   input  logic [DIR_W-1:0]      dir_x,
   input  logic [DIR_W-1:0]      dir_y,
   input  logic [DIR_W-1:0]      dir_z,
   output logic                  busy,
   output logic                  done,
   output ray_setup_type         ray
);

   localparam logic signed [T_W-1:0] T_NEG = {1'b1, {(T_W-1){1'b0}}};
   localparam logic signed [T_W-1:0] T_POS = {1'b0, {(T_W-1){1'b1}}};
   localparam logic [NUM_W-1:0] RECIP_NUM = NUM_W'(64'h1_0000_0000);

   setup_state_type        state_ff, state_in;
   logic [1:0]             ax_ff, ax_in;
   logic [2:0][ORG_W-1:0]  o_ff, o_in;
   logic [2:0][DIR_W-1:0]  d_ff, d_in;
   logic signed [T_W-1:0]  tnear_ff, tnear_in;
   logic signed [T_W-1:0]  tfar_ff, tfar_in;
   logic signed [T_W-1:0]  t1_ff, t1_in;
   logic                   miss_ff, miss_in;
   logic [2:0][POS_W-1:0]  p_ff, p_in;
   logic [2:0][IDX_W-1:0]  idx_ff, idx_in;
   logic [2:0][INC_W-1:0]  inc_ff, inc_in;
   logic [2:0][BT_W-1:0]   bt_ff, bt_in;
   logic [2:0]             sgn_ff, sgn_in;

   logic                   alu_start;
   alu_op_type             alu_op;
   logic [MCAND_W-1:0]     alu_a;
   logic [MAG_W-1:0]       alu_b;
   logic                   alu_done;
   logic [ACC_W-1:0]       alu_res;

   logic signed [ORG_W-1:0] cur_o;
   logic [DIR_W-1:0]        cur_d;
   logic [CFG_W-1:0]        cur_n;
   logic [POS_W-2:0]        n_pos;
   logic                    dneg, dzero;
   logic [MAG_W-1:0]        dmag;
   logic signed [25:0]      x1, x2, xsel, xabs;
   logic                    xneg;
   logic [NUM_W-1:0]        num;
   logic signed [T_W-1:0]   tq, lo, hi;
   logic signed [61:0]      sprod;
   logic signed [46:0]      v;
   logic [POS_W-1:0]        v_clamp;
   logic [IDX_W-1:0]        idx_raw, idx_cl, n_m1;
   logic [POS_W:0]          dist_w;
   logic [2:0]              out_box;
   logic [1:0]              ax_next;

   function automatic logic out_of_box(input logic [ORG_W-1:0] o, input logic [CFG_W-1:0] n);
      logic signed [ORG_W:0] lim;
      lim = $signed({4'b0, n, 16'b0});
      return ($signed(o) < 0) || ($signed({o[ORG_W-1], o}) > lim);
   endfunction

   vrt_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   always_comb begin
      cur_o   = $signed(o_ff[ax_ff]);
      cur_d   = d_ff[ax_ff];
      cur_n   = cells_n[ax_ff];
      n_pos   = {cur_n, 16'b0};
      dneg    = cur_d[DIR_W-1];
      dzero   = (cur_d == '0);
      dmag    = dneg ? MAG_W'(~cur_d + 1'b1) : MAG_W'(cur_d);
      for (int a = 0; a < 3; a++) begin
         out_box[a] = out_of_box(o_ff[a], cells_n[a]);
      end

      x1   = -(26'(cur_o));
      x2   = $signed({5'b0, n_pos}) - 26'(cur_o);
      xsel = (state_ff == SU_SLAB_GO1 || state_ff == SU_SLAB_WT1) ? x1 : x2;
      xneg = xsel[25];
      xabs = xneg ? -xsel : xsel;
      num  = {1'b0, xabs[24:0], 16'b0};
      tq   = (xneg ^ dneg) ? -$signed({2'b0, alu_res[NUM_W-1:0]})
                           : $signed({2'b0, alu_res[NUM_W-1:0]});
      lo   = (t1_ff < tq) ? t1_ff : tq;
      hi   = (t1_ff < tq) ? tq : t1_ff;

      sprod = dneg ? -$signed({1'b0, alu_res}) : $signed({1'b0, alu_res});
      v     = 47'(cur_o) + 47'($signed(sprod[61:16]));
      if (v < 0) begin
         v_clamp = '0;
      end else if (v > $signed({26'b0, n_pos})) begin
         v_clamp = {1'b0, n_pos};
      end else begin
         v_clamp = v[POS_W-1:0];
      end

      idx_raw = p_ff[ax_ff][POS_W-1:FRAC_W];
      n_m1    = {1'b0, cur_n} - 1'b1;
      idx_cl  = (idx_raw > n_m1) ? n_m1 : idx_raw;
      if (!dneg) begin
         dist_w = {1'b0, (idx_ff[ax_ff] + 1'b1), 16'b0} - {1'b0, p_ff[ax_ff]};
      end else begin
         dist_w = {1'b0, p_ff[ax_ff]} - {1'b0, idx_ff[ax_ff], 16'b0};
      end

      ax_next = ax_ff + 1'b1;

      alu_start = 1'b0;
      alu_op    = OP_DIV;
      alu_a     = {{(MCAND_W-NUM_W){1'b0}}, num};
      alu_b     = dmag;

      state_in = state_ff;
      ax_in    = ax_ff;
      o_in     = o_ff;
      d_in     = d_ff;
      tnear_in = tnear_ff;
      tfar_in  = tfar_ff;
      t1_in    = t1_ff;
      miss_in  = miss_ff;
      p_in     = p_ff;
      idx_in   = idx_ff;
      inc_in   = inc_ff;
      bt_in    = bt_ff;
      sgn_in   = sgn_ff;

      case (state_ff)
         SU_IDLE: begin
            if (start) begin
               o_in     = {origin_z, origin_y, origin_x};
               d_in     = {dir_z, dir_y, dir_x};
               miss_in  = 1'b0;
               ax_in    = '0;
               tnear_in = T_NEG;
               tfar_in  = T_POS;
               state_in = SU_CHECK;
            end
         end
         SU_CHECK: begin
            if (out_box == '0) begin
               for (int a = 0; a < 3; a++) begin
                  p_in[a] = o_ff[a][POS_W-1:0];
               end
               state_in = SU_CELL;
            end else begin
               state_in = SU_SLAB_GO1;
            end
         end
         SU_SLAB_GO1: begin
            if (dzero) begin
               if (out_box[ax_ff]) begin
                  miss_in = 1'b1;
               end
               ax_in    = (ax_ff == AX_LAST) ? 2'd0 : ax_next;
               state_in = (ax_ff == AX_LAST) ? SU_DECIDE : SU_SLAB_GO1;
            end else begin
               alu_start = 1'b1;
               state_in  = SU_SLAB_WT1;
            end
         end
         SU_SLAB_WT1: begin
            if (alu_done) begin
               t1_in    = tq;
               state_in = SU_SLAB_GO2;
            end
         end
         SU_SLAB_GO2: begin
            alu_start = 1'b1;
            state_in  = SU_SLAB_WT2;
         end
         SU_SLAB_WT2: begin
            if (alu_done) begin
               if (lo > tnear_ff) begin
                  tnear_in = lo;
               end
               if (hi < tfar_ff) begin
                  tfar_in = hi;
               end
               state_in = SU_SLAB_UPD;
            end
         end
         SU_SLAB_UPD: begin
            ax_in    = (ax_ff == AX_LAST) ? 2'd0 : ax_next;
            state_in = (ax_ff == AX_LAST) ? SU_DECIDE : SU_SLAB_GO1;
         end
         SU_DECIDE: begin
            ax_in = '0;
            if (miss_ff || (tnear_ff > tfar_ff) || (tfar_ff < 0)) begin
               miss_in  = 1'b1;
               state_in = SU_DONE;
            end else begin
               state_in = SU_ENTRY_GO;
            end
         end
         SU_ENTRY_GO: begin
            alu_start = 1'b1;
            alu_op    = OP_MUL;
            alu_a     = tnear_ff[MCAND_W-1:0];
            state_in  = SU_ENTRY_WT;
         end
         SU_ENTRY_WT: begin
            if (alu_done) begin
               p_in[ax_ff] = v_clamp;
               ax_in       = (ax_ff == AX_LAST) ? 2'd0 : ax_next;
               state_in    = (ax_ff == AX_LAST) ? SU_CELL : SU_ENTRY_GO;
            end
         end
         SU_CELL: begin
            idx_in[ax_ff] = idx_cl;
            sgn_in[ax_ff] = dneg || dzero;
            if (dzero) begin
               inc_in[ax_ff] = '1;
               bt_in[ax_ff]  = '1;
               ax_in         = (ax_ff == AX_LAST) ? 2'd0 : ax_next;
               state_in      = (ax_ff == AX_LAST) ? SU_DONE : SU_CELL;
            end else begin
               state_in = SU_REC_GO;
            end
         end
         SU_REC_GO: begin
            alu_start = 1'b1;
            alu_a     = {{(MCAND_W-NUM_W){1'b0}}, RECIP_NUM};
            state_in  = SU_REC_WT;
         end
         SU_REC_WT: begin
            if (alu_done) begin
               inc_in[ax_ff] = alu_res[INC_W-1:0];
               state_in      = SU_BT_GO;
            end
         end
         SU_BT_GO: begin
            alu_start = 1'b1;
            alu_op    = OP_MUL;
            alu_a     = {{(MCAND_W-INC_W){1'b0}}, inc_ff[ax_ff]};
            alu_b     = dist_w[MAG_W-1:0];
            state_in  = SU_BT_WT;
         end
         SU_BT_WT: begin
            if (alu_done) begin
               bt_in[ax_ff] = {{(BT_W-(ACC_W-FRAC_W)){1'b0}}, alu_res[ACC_W-1:FRAC_W]};
               ax_in        = (ax_ff == AX_LAST) ? 2'd0 : ax_next;
               state_in     = (ax_ff == AX_LAST) ? SU_DONE : SU_CELL;
            end
         end
         SU_DONE: begin
            state_in = SU_IDLE;
         end
         default: begin
            state_in = SU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SU_IDLE;
         ax_ff    <= '0;
         miss_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         miss_ff  <= miss_in;
      end
      o_ff     <= o_in;
      d_ff     <= d_in;
      tnear_ff <= tnear_in;
      tfar_ff  <= tfar_in;
      t1_ff    <= t1_in;
      p_ff     <= p_in;
      idx_ff   <= idx_in;
      inc_ff   <= inc_in;
      bt_ff    <= bt_in;
      sgn_ff   <= sgn_in;
   end

   assign busy         = (state_ff != SU_IDLE);
   assign done         = (state_ff == SU_DONE);
   assign ray.miss     = miss_ff;
   assign ray.all_zero = (d_ff == '0);
   assign ray.sgn      = sgn_ff;
   assign ray.idx      = idx_ff;
   assign ray.bt       = bt_ff;
   assign ray.inc      = inc_ff;

endmodule

### hdl/vrt_walk.sv
// ----------------------------------------------------------------------------
// vrt_walk
// Cell stepper: picks the axis with the nearest boundary, advances one cell
// per transfer and holds the result register.
// ----------------------------------------------------------------------------
module vrt_walk import vrt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  ray_setup_type         ray,
   input  logic [2:0][CFG_W-1:0] cells_n,
   input  logic                  rsp_stall,
   output logic                  active,
   output logic                  rsp_valid,
   output logic [VOX_W-1:0]      rsp_voxel_x,
   output logic [VOX_W-1:0]      rsp_voxel_y,
   output logic [VOX_W-1:0]      rsp_voxel_z,
   output logic                  rsp_hit,
   output logic                  rsp_last
);

   logic                  active_ff, active_in;
   logic                  miss_ff, miss_in;
   logic                  allz_ff, allz_in;
   logic [2:0]            sgn_ff, sgn_in;
   logic [2:0][IDX_W-1:0] idx_ff, idx_in;
   logic [2:0][BT_W-1:0]  bt_ff, bt_in;
   logic [2:0][INC_W-1:0] inc_ff, inc_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  vld_ff, vld_in;
   logic [2:0][VOX_W-1:0] vox_ff, vox_in;
   logic                  hit_ff, hit_in;
   logic                  last_ff, last_in;

   logic [1:0]            ax;
   logic [BT_W:0]         sum;
   logic [2:0][IDX_W-1:0] idx_nx;
   logic [IDX_W-1:0]      n_m1;
   logic                  stop, emit, last_now;

   always_comb begin
      if (bt_ff[0] < bt_ff[1]) begin
         ax = (bt_ff[0] < bt_ff[2]) ? 2'd0 : 2'd2;
      end else begin
         ax = (bt_ff[1] < bt_ff[2]) ? 2'd1 : 2'd2;
      end
      sum        = {1'b0, bt_ff[ax]} + {{(BT_W+1-INC_W){1'b0}}, inc_ff[ax]};
      idx_nx     = idx_ff;
      idx_nx[ax] = sgn_ff[ax] ? idx_ff[ax] - 1'b1 : idx_ff[ax] + 1'b1;
      stop       = allz_ff;
      for (int a = 0; a < 3; a++) begin
         n_m1 = {1'b0, cells_n[a]} - 1'b1;
         if ($signed(idx_nx[a]) < 0 || $signed(idx_nx[a]) > $signed(n_m1)) begin
            stop = 1'b1;
         end
      end
      emit     = active_ff && (!vld_ff || !rsp_stall);
      last_now = miss_ff || stop || (cnt_ff == CNT_W'(MAX_RESULTS - 1));

      active_in = active_ff;
      miss_in   = miss_ff;
      allz_in   = allz_ff;
      sgn_in    = sgn_ff;
      idx_in    = idx_ff;
      bt_in     = bt_ff;
      inc_in    = inc_ff;
      cnt_in    = cnt_ff;
      vld_in    = vld_ff && rsp_stall;
      vox_in    = vox_ff;
      hit_in    = hit_ff;
      last_in   = last_ff;

      if (load) begin
         active_in = 1'b1;
         miss_in   = ray.miss;
         allz_in   = ray.all_zero;
         sgn_in    = ray.sgn;
         idx_in    = ray.idx;
         bt_in     = ray.bt;
         inc_in    = ray.inc;
         cnt_in    = '0;
      end else if (emit) begin
         vld_in  = 1'b1;
         hit_in  = !miss_ff;
         last_in = last_now;
         for (int a = 0; a < 3; a++) begin
            vox_in[a] = miss_ff ? '0 : idx_ff[a][VOX_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (last_now) begin
            active_in = 1'b0;
         end else begin
            idx_in    = idx_nx;
            bt_in[ax] = sum[BT_W] ? '1 : sum[BT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         vld_ff    <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         vld_ff    <= vld_in;
         cnt_ff    <= cnt_in;
      end
      miss_ff <= miss_in;
      allz_ff <= allz_in;
      sgn_ff  <= sgn_in;
      idx_ff  <= idx_in;
      bt_ff   <= bt_in;
      inc_ff  <= inc_in;
      vox_ff  <= vox_in;
      hit_ff  <= hit_in;
      last_ff <= last_in;
   end

   assign active      = active_ff;
   assign rsp_valid   = vld_ff;
   assign rsp_voxel_x = vox_ff[0];
   assign rsp_voxel_y = vox_ff[1];
   assign rsp_voxel_z = vox_ff[2];
   assign rsp_hit     = hit_ff;
   assign rsp_last    = last_ff;

`ifndef SYNTHESIS
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load |-> !active_ff) else $error("ray loaded during a run");
   a_cnt_cap: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> cnt_ff < CNT_W'(MAX_RESULTS)) else $error("result cap exceeded");
   a_miss_last: assert property (@(posedge clock) disable iff (reset)
      vld_ff && !hit_ff |-> last_ff) else $error("miss result without last");
`endif

endmodule

### hdl/voxel_ray_traversal_3d.sv
// Ray setup runs through the shared one-bit-per-cycle divide/multiply unit: up to 9 divides
// and 6 multiplies for an outside origin, 3 of each for an inside one.
// Throughput: once setup is done, one voxel per cycle while rsp_stall is low; one ray at a time.
// Reset: synchronous; clears the sequencers and sets cells_x/y/z to 16.
// ----------------------------------------------------------------------------
// voxel_ray_traversal_3d
// 3D DDA voxel traversal of one ray through a box of up to MAX_CELLS cells
// per axis.
// ----------------------------------------------------------------------------
module voxel_ray_traversal_3d import vrt_pkg::*; #(
   parameter int MAX_CELLS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ORG_W-1:0]     req_origin_x,
   input  logic [ORG_W-1:0]     req_origin_y,
   input  logic [ORG_W-1:0]     req_origin_z,
   input  logic [DIR_W-1:0]     req_dir_x,
   input  logic [DIR_W-1:0]     req_dir_y,
   input  logic [DIR_W-1:0]     req_dir_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [VOX_W-1:0]     rsp_voxel_x,
   output logic [VOX_W-1:0]     rsp_voxel_y,
   output logic [VOX_W-1:0]     rsp_voxel_z,
   output logic                 rsp_hit,
   output logic                 rsp_last
);

   logic [2:0][CFG_W-1:0] cells_ff, cells_in;
   logic [2:0][CFG_W-1:0] cells_n;
   logic                  su_busy, su_done, walk_active;
   ray_setup_type         ray;

   always_comb begin
      cells_in = cells_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CELLS_X: cells_in[0] = csr_data;
            CSR_CELLS_Y: cells_in[1] = csr_data;
            CSR_CELLS_Z: cells_in[2] = csr_data;
            default:     cells_in = cells_ff;
         endcase
      end
      for (int a = 0; a < 3; a++) begin
         if (cells_ff[a] == '0) begin
            cells_n[a] = CFG_W'(1);
         end else if (cells_ff[a] > CFG_W'(MAX_CELLS)) begin
            cells_n[a] = CFG_W'(MAX_CELLS);
         end else begin
            cells_n[a] = cells_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_ff <= {3{CFG_W'(16)}};
      end else begin
         cells_ff <= cells_in;
      end
   end

   assign req_stall = su_busy || walk_active;

   vrt_setup u_setup (
      .clock    (clock),
      .reset    (reset),
      .start    (req_valid && !req_stall),
      .cells_n  (cells_n),
      .origin_x (req_origin_x),
      .origin_y (req_origin_y),
      .origin_z (req_origin_z),
      .dir_x    (req_dir_x),
      .dir_y    (req_dir_y),
      .dir_z    (req_dir_z),
      .busy     (su_busy),
      .done     (su_done),
      .ray      (ray)
   );

   vrt_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .load        (su_done),
      .ray         (ray),
      .cells_n     (cells_n),
      .rsp_stall   (rsp_stall),
      .active      (walk_active),
      .rsp_valid   (rsp_valid),
      .rsp_voxel_x (rsp_voxel_x),
      .rsp_voxel_y (rsp_voxel_y),
      .rsp_voxel_z (rsp_voxel_z),
      .rsp_hit     (rsp_hit),
      .rsp_last    (rsp_last)
   );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for voxel_ray_traversal_3d.
//
// Rays are sent over the request channel. A built-in DDA predictor computes
// the expected cell run of each accepted ray and queues it. A monitor checks
// every response transfer against the oldest queued cell, field by field.
//
// Covered:
//   - directed rays: field extremes, zero directions, far-face starts,
//     boundary starts and the result cap
//   - several box sizes, including out-of-range register values
//   - input back-pressure while the response side is held off
//   - random rays aimed near the box, mixed with random noise
// Both sides insert random idle gaps.
// ----------------------------------------------------------------------------
module tb import vrt_pkg::*; ();

   localparam int      MAX_CELLS = 16;
   localparam longint  ONE       = 64'sd65536;
   localparam longint  T_BIG     = 64'sd1 <<< 62;
   localparam longint unsigned TIME_SAT = (64'd1 << 48) - 64'd1;
   localparam longint unsigned INC_SAT  = (64'd1 << 33) - 64'd1;

   typedef struct packed {
      logic [VOX_W-1:0] x;
      logic [VOX_W-1:0] y;
      logic [VOX_W-1:0] z;
      logic             hit;
      logic             last;
   } cell_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [ORG_W-1:0]     req_origin_x;
   logic [ORG_W-1:0]     req_origin_y;
   logic [ORG_W-1:0]     req_origin_z;
   logic [DIR_W-1:0]     req_dir_x;
   logic [DIR_W-1:0]     req_dir_y;
   logic [DIR_W-1:0]     req_dir_z;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [VOX_W-1:0]     rsp_voxel_x;
   logic [VOX_W-1:0]     rsp_voxel_y;
   logic [VOX_W-1:0]     rsp_voxel_z;
   logic                 rsp_hit;
   logic                 rsp_last;

   cell_type    cell_q[$];
   logic [CFG_W-1:0] box_cells[3];
   int          err_count;
   int          hold_cycles;
   bit          gaps_on;

   voxel_ray_traversal_3d #(.MAX_CELLS(MAX_CELLS)) i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_origin_x (req_origin_x),
      .req_origin_y (req_origin_y),
      .req_origin_z (req_origin_z),
      .req_dir_x    (req_dir_x),
      .req_dir_y    (req_dir_y),
      .req_dir_z    (req_dir_z),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_voxel_x  (rsp_voxel_x),
      .rsp_voxel_y  (rsp_voxel_y),
      .rsp_voxel_z  (rsp_voxel_z),
      .rsp_hit      (rsp_hit),
      .rsp_last     (rsp_last)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint box_size(logic [CFG_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_CELLS) return MAX_CELLS;
      return longint'(r);
   endfunction

   // DDA walk of one ray; queue every cell it crosses
   task automatic predict_ray(input logic [2:0][ORG_W-1:0] org,
                              input logic [2:0][DIR_W-1:0] dir);
      longint o[3], d[3], n[3], p[3];
      longint t1, t2, lo, hi, tnear, tfar, v, dist_q;
      longint unsigned bt[3], inc[3], mag, sum;
      int cur_idx[3];
      bit in_box, miss, stop;
      int ax, cnt;
      cell_type c;
      in_box = 1;
      miss = 0;
      tnear = -T_BIG;
      tfar = T_BIG;
      for (int a = 0; a < 3; a++) begin
         n[a] = box_size(box_cells[a]);
         o[a] = longint'(signed'(org[a]));
         d[a] = longint'(signed'(dir[a]));
         if (o[a] < 0 || o[a] > n[a] * ONE) in_box = 0;
      end
      if (in_box) begin
         for (int a = 0; a < 3; a++) p[a] = o[a];
      end else begin
         for (int a = 0; a < 3; a++) begin
            if (d[a] == 0) begin
               if (o[a] < 0 || o[a] > n[a] * ONE) miss = 1;
            end else begin
               t1 = ((0 - o[a]) * ONE) / d[a];
               t2 = ((n[a] * ONE - o[a]) * ONE) / d[a];
               lo = (t1 < t2) ? t1 : t2;
               hi = (t1 < t2) ? t2 : t1;
               if (lo > tnear) tnear = lo;
               if (hi < tfar) tfar = hi;
            end
         end
         if (miss || tnear > tfar || tfar < 0) begin
            c = '{x: '0, y: '0, z: '0, hit: 1'b0, last: 1'b1};
            cell_q.push_back(c);
            return;
         end
         for (int a = 0; a < 3; a++) begin
            v = o[a] + ((tnear * d[a]) >>> 16);
            if (v < 0) v = 0;
            if (v > n[a] * ONE) v = n[a] * ONE;
            p[a] = v;
         end
      end
      for (int a = 0; a < 3; a++) begin
         v = p[a] >>> 16;
         if (v > n[a] - 1) v = n[a] - 1;
         cur_idx[a] = int'(v);
         if (d[a] == 0) begin
            inc[a] = INC_SAT;
            bt[a] = TIME_SAT;
         end else begin
            mag = longint'((d[a] < 0) ? -d[a] : d[a]);
            dist_q = (d[a] > 0) ? ((v + 1) * ONE - p[a]) : (p[a] - v * ONE);
            inc[a] = (64'd1 << 32) / mag;
            bt[a] = (longint'(dist_q) * inc[a]) >> 16;
         end
      end
      cnt = 0;
      do begin
         c.x = cur_idx[0][3:0];
         c.y = cur_idx[1][3:0];
         c.z = cur_idx[2][3:0];
         c.hit = 1'b1;
         cnt++;
         if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
            stop = 1;
         end else begin
            if (bt[0] < bt[1]) ax = (bt[0] < bt[2]) ? 0 : 2;
            else ax = (bt[1] < bt[2]) ? 1 : 2;
            cur_idx[ax] += (d[ax] > 0) ? 1 : -1;
            sum = bt[ax] + inc[ax];
            bt[ax] = (sum > TIME_SAT) ? TIME_SAT : sum;
            stop = 0;
            for (int a = 0; a < 3; a++)
               if (cur_idx[a] < 0 || cur_idx[a] > n[a] - 1) stop = 1;
         end
         c.last = stop || cnt >= MAX_RESULTS;
         cell_q.push_back(c);
      end while (!c.last);
   endtask

   task automatic send_ray(input logic [ORG_W-1:0] ox, oy, oz,
                           input logic [DIR_W-1:0] dx, dy, dz);
      int gap;
      bit taken;
      gap = gaps_on ? gap_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_origin_x <= ox;
      req_origin_y <= oy;
      req_origin_z <= oz;
      req_dir_x    <= dx;
      req_dir_y    <= dy;
      req_dir_z    <= dz;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      predict_ray({oz, oy, ox}, {dz, dy, dx});
   endtask

   // hold the sender until every queued cell has arrived
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cell_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_box(input logic [CFG_W-1:0] cx, cy, cz);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CELLS_X;
      csr_data  <= cx;
      @(posedge clock);
      csr_index <= CSR_CELLS_Y;
      csr_data  <= cy;
      @(posedge clock);
      csr_index <= CSR_CELLS_Z;
      csr_data  <= cz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      box_cells[0] = cx;
      box_cells[1] = cy;
      box_cells[2] = cz;
      @(posedge clock);
   endtask

   task automatic send_random_ray();
      logic [ORG_W-1:0] org[3];
      logic [DIR_W-1:0] dir[3];
      int mode;
      longint span;
      mode = $urandom_range(0, 99);
      for (int a = 0; a < 3; a++) begin
         span = box_size(box_cells[a]) + 8;
         if (mode < 80) begin
            org[a] = ORG_W'(longint'($urandom_range(0, 32'(span << 16))) - (4 << 16));
            if ($urandom_range(0, 9) == 0) org[a][15:0] = '0;
            dir[a] = ($urandom_range(0, 9) == 0) ? '0
                   : DIR_W'(int'($urandom_range(0, 131072)) - 65536);
         end else begin
            org[a] = ORG_W'($urandom);
            dir[a] = DIR_W'(int'($urandom_range(0, 131072)) - 65536);
         end
      end
      send_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
   endtask

   task automatic test_directed();
      // axis rays from the center, along x both ways and down z
      send_ray(24'h08_8000, 24'h08_8000, 24'h08_8000, 18'h10000, 18'h0, 18'h0);
      send_ray(24'h08_8000, 24'h08_8000, 24'h08_8000, -18'sd65536, 18'h0, 18'h0);
      send_ray(24'h08_8000, 24'h08_8000, 24'h08_8000, 18'h0, 18'h0, -18'sd65536);
      // tie order on a diagonal, and the result cap from a corner
      send_ray(24'h04_8000, 24'h04_8000, 24'h04_8000, 18'h10000, 18'h10000, 18'h10000);
      send_ray(24'h0, 24'h0, 24'h0, 18'h10000, 18'h10000, 18'h10000);
      send_ray(24'h10_0000, 24'h10_0000, 24'h10_0000, -18'sd65536, -18'sd65536,
               -18'sd65536);
      // zero direction inside and outside
      send_ray(24'h03_4000, 24'h07_0000, 24'h0F_FFFF, 18'h0, 18'h0, 18'h0);
      send_ray(24'hFF_0000, 24'h07_0000, 24'h07_0000, 18'h0, 18'h0, 18'h0);
      send_ray(24'h02_0000, 24'h20_0000, 24'h02_0000, 18'h10000, 18'h0, 18'h0);
      // entry from outside, and pointing away
      send_ray(24'hFC_0000, 24'h05_2000, 24'h09_C000, 18'h10000, 18'h02000, -18'sd4096);
      send_ray(24'hFC_0000, 24'h05_2000, 24'h09_C000, -18'sd65536, 18'h0, 18'h0);
      send_ray(24'h14_0000, 24'h0A_0000, 24'h06_0000, -18'sd30000, 18'h00100, 18'h3);
      // far-face start and far-face entry
      send_ray(24'h10_0000, 24'h08_8000, 24'h08_8000, 18'h10000, 18'h0, 18'h0);
      send_ray(24'h18_0000, 24'h08_8000, 24'h08_8000, -18'sd65536, 18'h08000, 18'h0);
      // negative step from an integer coordinate
      send_ray(24'h08_0000, 24'h05_0000, 24'h03_0000, -18'sd65536, -18'sd1, 18'h1);
      // field extremes
      send_ray(24'h7F_FFFF, 24'h7F_FFFF, 24'h7F_FFFF, -18'sd65536, -18'sd65536,
               -18'sd65536);
      send_ray(24'h80_0000, 24'h80_0000, 24'h80_0000, 18'h10000, 18'h10000, 18'h10000);
      send_ray(24'h80_0000, 24'h08_0000, 24'h08_0000, 18'h1, 18'h0, 18'h0);
      send_ray(24'h00_0001, 24'h0F_FFFF, 24'h00_FFFF, 18'h1, -18'sd1, 18'h0FFFF);
      send_ray(24'h7F_FFFF, 24'h80_0000, 24'h08_0000, 18'h10000, -18'sd65536, 18'h0);
   endtask

   task automatic test_box_sizes();
      logic [CFG_W-1:0] sizes[6][3];
      sizes = '{'{5'd1, 5'd1, 5'd1}, '{5'd0, 5'd0, 5'd0}, '{5'd31, 5'd17, 5'd5},
                '{5'd2, 5'd16, 5'd3}, '{5'd7, 5'd1, 5'd12}, '{5'd16, 5'd16, 5'd16}};
      for (int s = 0; s < 6; s++) begin
         write_box(sizes[s][0], sizes[s][1], sizes[s][2]);
         send_ray(24'h0, 24'h0, 24'h0, 18'h10000, 18'h10000, 18'h10000);
         repeat (12) send_random_ray();
      end
   endtask

   task automatic test_backpressure();
      drain();
      hold_cycles = 1500;
      gaps_on = 0;
      repeat (6) send_random_ray();
      gaps_on = 1;
      drain();
   endtask

   task automatic test_random();
      gaps_on = 0;
      repeat (50) send_random_ray();
      gaps_on = 1;
      repeat (70) send_random_ray();
      write_box(5'($urandom_range(1, 16)), 5'($urandom_range(1, 16)),
                5'($urandom_range(1, 16)));
      repeat (50) send_random_ray();
      drain();
   endtask

   // response stall: random runs, or a long hold-off on request
   initial begin
      int stall_run, free_run;
      stall_run = 0;
      free_run = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (!gaps_on) begin
            rsp_stall <= 1'b0;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else if (free_run > 0) begin
            rsp_stall <= 1'b0;
            free_run--;
         end else begin
            stall_run = gap_len();
            free_run = $urandom_range(0, 20);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      cell_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cell_q.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected transfer: x %0d y %0d z %0d hit %0b last %0b",
                        rsp_voxel_x, rsp_voxel_y, rsp_voxel_z, rsp_hit, rsp_last);
         end else begin
            want = cell_q.pop_front();
            if (rsp_voxel_x !== want.x || rsp_voxel_y !== want.y ||
                rsp_voxel_z !== want.z || rsp_hit !== want.hit ||
                rsp_last !== want.last) begin
               err_count++;
               if (err_count <= 10)
                  $display("mismatch: exp x %0d y %0d z %0d hit %0b last %0b, got x %0d y %0d z %0d hit %0b last %0b",
                           want.x, want.y, want.z, want.hit, want.last,
                           rsp_voxel_x, rsp_voxel_y, rsp_voxel_z, rsp_hit, rsp_last);
            end
         end
      end
   end

   initial begin
      #50_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      err_count = 0;
      hold_cycles = 0;
      gaps_on = 1;
      box_cells[0] = 5'd16;
      box_cells[1] = 5'd16;
      box_cells[2] = 5'd16;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = CSR_CELLS_X;
      csr_data = '0;
      req_valid = 1'b0;
      req_origin_x = '0;
      req_origin_y = '0;
      req_origin_z = '0;
      req_dir_x = '0;
      req_dir_y = '0;
      req_dir_z = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_box_sizes();
      test_backpressure();
      test_random();
      if (err_count == 0 && cell_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### voxel_ray_traversal_3d.f
hdl/vrt_pkg.sv
hdl/vrt_alu.sv
hdl/vrt_setup.sv
hdl/vrt_walk.sv
hdl/voxel_ray_traversal_3d.sv
verif/tb.sv
